// ----- sv/srp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the segment repulsion pipeline.
// No dependencies; imported by every module of the block.
package srp_pkg;

    localparam int COORD_W    = 32;
    localparam int MASS_W     = 31;
    localparam int RADIUS_W   = 31;
    localparam int MARGIN_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_MARGIN = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd0;
    localparam logic [MARGIN_W-1:0] HALF_ONE     = 16'd32768;
    localparam logic [14:0]         U_SCALE      = 15'd20000;

    localparam int S_TDATA_W = 224;
    localparam int M_TDATA_W = 64;

    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int MPROD_W    = 65;
    localparam int DSQ_W      = 66;
    localparam int CROSS_W    = 67;
    localparam int NUM_MAG_W  = 63;
    localparam int DIVISOR_W  = 66;
    localparam int DIVIDEND_W = NUM_MAG_W + FRAC_W;
    localparam int QUO_W      = 33;
    localparam int REM_W      = DIVISOR_W + QUO_W;

    localparam logic [DSQ_W-1:0]   DEG_MIN  = 66'd3;
    localparam logic [QUO_W-1:0]   POS_LIM  = 33'h07FFFFFFF;
    localparam logic [QUO_W-1:0]   NEG_LIM  = 33'h080000000;
    localparam logic [COORD_W-1:0] SAT_POS  = 32'h7FFFFFFF;
    localparam logic [COORD_W-1:0] SAT_NEG  = 32'h80000000;

    typedef struct packed {
        logic [MASS_W-1:0]         mass;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] seg_by;
        logic signed [COORD_W-1:0] seg_bx;
        logic signed [COORD_W-1:0] seg_ay;
        logic signed [COORD_W-1:0] seg_ax;
    } srp_item_t;

    localparam int ITEM_W = $bits(srp_item_t);

    typedef struct packed {
        logic                  hit;
        logic                  neg_x;
        logic                  neg_y;
        logic [DIVISOR_W-1:0]  divisor;
        logic [DIVIDEND_W-1:0] num_x;
        logic [DIVIDEND_W-1:0] num_y;
    } srp_div_in_t;

    typedef struct packed {
        logic             hit;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [QUO_W-1:0] q_x;
        logic [QUO_W-1:0] q_y;
    } srp_quo_t;

endpackage

// ----- sv/segment_particle_repulsion_force.sv -----
`timescale 1ns / 1ps
// Top level of the segment repulsion block: input skid stage, configuration
// registers, output saturation register. Depends on srp_pkg, srp_geom, srp_div.
//
// Each input transfer on the s_ channel carries a wall segment, a particle
// centre and its mass; exactly one result transfer on the m_ channel follows,
// in the same order. m_tuser carries the hit flag and m_tdata the two force
// components, which are zero when there is no hit.
// The datapath is a single pipeline of 42 register stages: seven for the
// geometry and range tests, one overflow check and 33 quotient-bit stages of
// the divider, and the output register. With m_tready held high one item is
// taken every cycle.
// When the receiver stalls the whole pipeline holds; one further input
// transfer is then caught in a skid register, after which s_tready is low
// until the pipeline moves again. No item is lost or repeated.
// Configuration writes take effect on the next clock edge; the user must make them
// only while the block is empty; the block does not enforce this. A synchronous reset
// empties the pipeline and restores radius to one and the edge margin to zero.
module segment_particle_repulsion_force (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // seg_ax, seg_ay, seg_bx, seg_by, pos_x, pos_y, mass, one zero bit
    input  logic [srp_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // force_x, force_y
    output logic [srp_pkg::M_TDATA_W-1:0]    m_tdata,
    // hit
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [srp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srp_pkg::RADIUS_W-1:0]     cfg_wdata
);
    import srp_pkg::*;

    logic                 en;
    logic                 s_fire;
    srp_item_t            s_item_w;
    srp_item_t            skid_item_reg;
    logic                 skid_vld_reg, skid_vld_next;
    srp_item_t            front_item_w;
    logic                 front_vld_w;

    logic [RADIUS_W-1:0]  radius_reg, radius_next;
    logic [MARGIN_W-1:0]  margin_reg, margin_next;

    logic                 geo_vld_w;
    srp_div_in_t          geo_data_w;
    logic                 quo_vld_w;
    srp_quo_t             quo_w;

    logic [COORD_W-1:0]   fx_w, fy_w;
    logic                 out_vld_reg, out_vld_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_hit_reg;

    assign en           = !out_vld_reg || m_tready;
    assign s_tready     = !skid_vld_reg;
    assign s_fire       = s_tvalid && s_tready;
    assign s_item_w     = s_tdata[ITEM_W-1:0];
    assign front_vld_w  = skid_vld_reg || s_fire;
    assign front_item_w = skid_vld_reg ? skid_item_reg : s_item_w;

    always_comb begin
        skid_vld_next = skid_vld_reg;
        if (en) begin
            skid_vld_next = 1'b0;
        end else if (s_fire) begin
            skid_vld_next = 1'b1;
        end
    end

    always_comb begin
        radius_next = radius_reg;
        margin_next = margin_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RADIUS: begin
                    radius_next = cfg_wdata;
                end
                REG_EDGE_MARGIN: begin
                    margin_next = cfg_wdata[MARGIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (en) begin
            out_vld_next = quo_vld_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            radius_reg   <= RADIUS_RESET;
            margin_reg   <= MARGIN_RESET;
        end else begin
            skid_vld_reg <= skid_vld_next;
            out_vld_reg  <= out_vld_next;
            radius_reg   <= radius_next;
            margin_reg   <= margin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !en) begin
            skid_item_reg <= s_item_w;
        end
    end

    srp_geom u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (front_vld_w),
        .in_item     (front_item_w),
        .radius      (radius_reg),
        .edge_margin (margin_reg),
        .out_valid   (geo_vld_w),
        .out_data    (geo_data_w)
    );

    srp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_vld_w),
        .in_data   (geo_data_w),
        .out_valid (quo_vld_w),
        .out_data  (quo_w)
    );

    always_comb begin
        if (!quo_w.neg_x) begin
            fx_w = (quo_w.ovf_x || quo_w.q_x > POS_LIM) ? SAT_POS : quo_w.q_x[COORD_W-1:0];
        end else begin
            fx_w = (quo_w.ovf_x || quo_w.q_x > NEG_LIM) ? SAT_NEG : -quo_w.q_x[COORD_W-1:0];
        end
        if (!quo_w.neg_y) begin
            fy_w = (quo_w.ovf_y || quo_w.q_y > POS_LIM) ? SAT_POS : quo_w.q_y[COORD_W-1:0];
        end else begin
            fy_w = (quo_w.ovf_y || quo_w.q_y > NEG_LIM) ? SAT_NEG : -quo_w.q_y[COORD_W-1:0];
        end
        if (!quo_w.hit) begin
            fx_w = '0;
            fy_w = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {fy_w, fx_w};
            out_hit_reg  <= quo_w.hit;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

// ----- sv/srp_geom.sv -----
`timescale 1ns / 1ps
// Seven-stage geometry pipeline: projection, range tests and radius test.
// Depends on srp_pkg; feeds the divider stage srp_div.
module srp_geom (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  srp_pkg::srp_item_t             in_item,
    input  logic [srp_pkg::RADIUS_W-1:0]   radius,
    input  logic [srp_pkg::MARGIN_W-1:0]   edge_margin,
    output logic                           out_valid,
    output srp_pkg::srp_div_in_t           out_data
);
    import srp_pkg::*;

    typedef struct packed {
        logic dok;
        logic cnz;
        logic neg_x;
        logic neg_y;
    } flag_t;

    typedef struct packed {
        logic [NUM_MAG_W-1:0] x;
        logic [NUM_MAG_W-1:0] y;
    } mag_t;

    logic [6:0] vld_reg;
    logic [6:0] vld_next;

    logic [MARGIN_W-1:0] hr_w;
    logic [29:0]         kh_reg;
    logic [61:0]         rr_reg;
    logic                hr_pos_reg;

    logic signed [DIFF_W-1:0] g1_rx_reg, g1_ry_reg, g1_wx_reg, g1_wy_reg;
    logic [MASS_W-1:0]        g1_mass_reg;

    logic signed [PROD_W-1:0]  g2_rxrx_reg, g2_ryry_reg, g2_wxrx_reg;
    logic signed [PROD_W-1:0]  g2_wyry_reg, g2_wxry_reg, g2_wyrx_reg;
    logic signed [MPROD_W-1:0] g2_mry_reg, g2_mrx_reg;
    logic signed [MPROD_W-1:0] mry_neg_w, mrx_neg_w;

    logic [DSQ_W-1:0]          g3_d_reg;
    logic signed [CROSS_W-1:0] g3_dot_reg, g3_c_reg;
    logic signed [CROSS_W-1:0] c_neg_w;
    mag_t                      g3_mag_reg;
    logic                      g3_mry_neg_reg, g3_mrx_pos_reg;

    logic [DSQ_W-1:0]          g4_d_reg;
    logic signed [CROSS_W-1:0] g4_dot_reg;
    logic [DIVISOR_W-1:0]      g4_cabs_reg;
    logic [48:0]               g4_mdl_reg, g4_mdh_reg;
    logic [62:0]               g4_kdl_reg, g4_kdh_reg;
    logic [63:0]               g4_rll_reg, g4_rlh_reg, g4_rhl_reg, g4_rhh_reg;
    flag_t                     g4_flg_reg;
    mag_t                      g4_mag_reg;

    logic [DSQ_W-1:0]        g5_d_reg;
    logic signed [82:0]      g5_dot16_reg;
    logic [DIVISOR_W-1:0]    g5_cabs_reg;
    logic [81:0]             g5_md_reg;
    logic [95:0]             g5_kd_reg;
    logic [127:0]            g5_rrd_reg;
    logic [65:0]             g5_cll_reg, g5_clh_reg, g5_chh_reg;
    flag_t                   g5_flg_reg;
    mag_t                    g5_mag_reg;

    logic signed [82:0]      g6_dot16_reg;
    logic [81:0]             g6_hid_reg;
    logic                    g6_tlo_reg, g6_uok_reg;
    logic [131:0]            g6_c2_reg;
    logic [127:0]            g6_rrd_reg;
    logic [DIVISOR_W-1:0]    g6_cabs_reg;
    flag_t                   g6_flg_reg;
    mag_t                    g6_mag_reg;

    logic                    thi_w, rok_w;
    srp_div_in_t             g7_out_reg;

    assign hr_w      = HALF_ONE - edge_margin;
    assign mry_neg_w = -g2_mry_reg;
    assign mrx_neg_w = -g2_mrx_reg;
    assign c_neg_w   = -g3_c_reg;
    assign thi_w     = g6_dot16_reg < $signed({1'b0, g6_hid_reg});
    assign rok_w     = g6_c2_reg < 132'(g6_rrd_reg);

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        kh_reg     <= U_SCALE * hr_w;
        rr_reg     <= radius * radius;
        hr_pos_reg <= edge_margin < HALF_ONE;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_rx_reg   <= {in_item.seg_bx[COORD_W-1], in_item.seg_bx}
                         - {in_item.seg_ax[COORD_W-1], in_item.seg_ax};
            g1_ry_reg   <= {in_item.seg_by[COORD_W-1], in_item.seg_by}
                         - {in_item.seg_ay[COORD_W-1], in_item.seg_ay};
            g1_wx_reg   <= {in_item.pos_x[COORD_W-1], in_item.pos_x}
                         - {in_item.seg_ax[COORD_W-1], in_item.seg_ax};
            g1_wy_reg   <= {in_item.pos_y[COORD_W-1], in_item.pos_y}
                         - {in_item.seg_ay[COORD_W-1], in_item.seg_ay};
            g1_mass_reg <= in_item.mass;

            g2_rxrx_reg <= g1_rx_reg * g1_rx_reg;
            g2_ryry_reg <= g1_ry_reg * g1_ry_reg;
            g2_wxrx_reg <= g1_wx_reg * g1_rx_reg;
            g2_wyry_reg <= g1_wy_reg * g1_ry_reg;
            g2_wxry_reg <= g1_wx_reg * g1_ry_reg;
            g2_wyrx_reg <= g1_wy_reg * g1_rx_reg;
            g2_mry_reg  <= $signed({1'b0, g1_mass_reg}) * g1_ry_reg;
            g2_mrx_reg  <= $signed({1'b0, g1_mass_reg}) * g1_rx_reg;

            g3_d_reg       <= $unsigned(g2_rxrx_reg) + $unsigned(g2_ryry_reg);
            g3_dot_reg     <= g2_wxrx_reg + g2_wyry_reg;
            g3_c_reg       <= g2_wxry_reg - g2_wyrx_reg;
            g3_mag_reg.x   <= g2_mry_reg[MPROD_W-1] ? mry_neg_w[NUM_MAG_W-1:0]
                                                    : g2_mry_reg[NUM_MAG_W-1:0];
            g3_mag_reg.y   <= g2_mrx_reg[MPROD_W-1] ? mrx_neg_w[NUM_MAG_W-1:0]
                                                    : g2_mrx_reg[NUM_MAG_W-1:0];
            g3_mry_neg_reg <= g2_mry_reg[MPROD_W-1];
            g3_mrx_pos_reg <= !g2_mrx_reg[MPROD_W-1] && (g2_mrx_reg != '0);

            g4_d_reg         <= g3_d_reg;
            g4_dot_reg       <= g3_dot_reg;
            g4_cabs_reg      <= g3_c_reg[CROSS_W-1] ? c_neg_w[DIVISOR_W-1:0]
                                                    : g3_c_reg[DIVISOR_W-1:0];
            g4_mdl_reg       <= edge_margin * g3_d_reg[32:0];
            g4_mdh_reg       <= edge_margin * g3_d_reg[65:33];
            g4_kdl_reg       <= kh_reg * g3_d_reg[32:0];
            g4_kdh_reg       <= kh_reg * g3_d_reg[65:33];
            g4_rll_reg       <= rr_reg[30:0] * g3_d_reg[32:0];
            g4_rlh_reg       <= rr_reg[30:0] * g3_d_reg[65:33];
            g4_rhl_reg       <= rr_reg[61:31] * g3_d_reg[32:0];
            g4_rhh_reg       <= rr_reg[61:31] * g3_d_reg[65:33];
            g4_flg_reg.dok   <= g3_d_reg >= DEG_MIN;
            g4_flg_reg.cnz   <= g3_c_reg != '0;
            g4_flg_reg.neg_x <= g3_mry_neg_reg ^ g3_c_reg[CROSS_W-1];
            g4_flg_reg.neg_y <= g3_mrx_pos_reg ^ g3_c_reg[CROSS_W-1];
            g4_mag_reg       <= g3_mag_reg;

            g5_d_reg     <= g4_d_reg;
            g5_dot16_reg <= {g4_dot_reg, 16'b0};
            g5_cabs_reg  <= g4_cabs_reg;
            g5_md_reg    <= 82'(g4_mdl_reg) + {g4_mdh_reg, 33'b0};
            g5_kd_reg    <= 96'(g4_kdl_reg) + {g4_kdh_reg, 33'b0};
            g5_rrd_reg   <= 128'(g4_rll_reg) + 128'({g4_rlh_reg, 33'b0})
                          + 128'({g4_rhl_reg, 31'b0}) + {g4_rhh_reg, 64'b0};
            g5_cll_reg   <= g4_cabs_reg[32:0] * g4_cabs_reg[32:0];
            g5_clh_reg   <= g4_cabs_reg[32:0] * g4_cabs_reg[65:33];
            g5_chh_reg   <= g4_cabs_reg[65:33] * g4_cabs_reg[65:33];
            g5_flg_reg   <= g4_flg_reg;
            g5_mag_reg   <= g4_mag_reg;

            g6_dot16_reg <= g5_dot16_reg;
            g6_hid_reg   <= {g5_d_reg, 16'b0} - g5_md_reg;
            g6_tlo_reg   <= g5_dot16_reg > $signed({1'b0, g5_md_reg});
            g6_uok_reg   <= 96'({g5_cabs_reg, 16'b0}) < g5_kd_reg;
            g6_c2_reg    <= 132'(g5_cll_reg) + 132'({g5_clh_reg, 34'b0})
                          + {g5_chh_reg, 66'b0};
            g6_rrd_reg   <= g5_rrd_reg;
            g6_cabs_reg  <= g5_cabs_reg;
            g6_flg_reg   <= g5_flg_reg;
            g6_mag_reg   <= g5_mag_reg;

            g7_out_reg.hit     <= g6_flg_reg.dok && g6_flg_reg.cnz && hr_pos_reg
                               && g6_tlo_reg && thi_w && g6_uok_reg && rok_w;
            g7_out_reg.neg_x   <= g6_flg_reg.neg_x;
            g7_out_reg.neg_y   <= g6_flg_reg.neg_y;
            g7_out_reg.divisor <= g6_cabs_reg;
            g7_out_reg.num_x   <= {g6_mag_reg.x, 16'b0};
            g7_out_reg.num_y   <= {g6_mag_reg.y, 16'b0};
        end
    end

    assign out_valid = vld_reg[6];
    assign out_data  = g7_out_reg;

endmodule

// ----- sv/srp_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Depends on srp_pkg; fed by srp_geom.
module srp_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  srp_pkg::srp_div_in_t  in_data,
    output logic                  out_valid,
    output srp_pkg::srp_quo_t     out_data
);
    import srp_pkg::*;

    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } side_t;

    logic [QUO_W:0]         vld_reg;
    logic [QUO_W:0]         vld_next;
    logic [REM_W-1:0]       rem_x_reg [QUO_W+1];
    logic [REM_W-1:0]       rem_y_reg [QUO_W+1];
    logic [QUO_W-1:0]       q_x_reg   [QUO_W+1];
    logic [QUO_W-1:0]       q_y_reg   [QUO_W+1];
    logic [DIVISOR_W-1:0]   div_reg   [QUO_W+1];
    side_t                  side_reg  [QUO_W+1];
    logic [REM_W-1:0]       lim_w;

    assign lim_w = {in_data.divisor, {QUO_W{1'b0}}};

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[QUO_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_x_reg[0]      <= REM_W'(in_data.num_x);
            rem_y_reg[0]      <= REM_W'(in_data.num_y);
            q_x_reg[0]        <= '0;
            q_y_reg[0]        <= '0;
            div_reg[0]        <= in_data.divisor;
            side_reg[0].hit   <= in_data.hit;
            side_reg[0].neg_x <= in_data.neg_x;
            side_reg[0].neg_y <= in_data.neg_y;
            side_reg[0].ovf_x <= REM_W'(in_data.num_x) >= lim_w;
            side_reg[0].ovf_y <= REM_W'(in_data.num_y) >= lim_w;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
        localparam int B = QUO_W - k;
        logic [REM_W-1:0] sh_w;
        logic             ge_x_w, ge_y_w;

        assign sh_w   = REM_W'(div_reg[k-1]) << B;
        assign ge_x_w = rem_x_reg[k-1] >= sh_w;
        assign ge_y_w = rem_y_reg[k-1] >= sh_w;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_x_reg[k] <= ge_x_w ? rem_x_reg[k-1] - sh_w : rem_x_reg[k-1];
                rem_y_reg[k] <= ge_y_w ? rem_y_reg[k-1] - sh_w : rem_y_reg[k-1];
                q_x_reg[k]   <= q_x_reg[k-1] | (QUO_W'(ge_x_w) << B);
                q_y_reg[k]   <= q_y_reg[k-1] | (QUO_W'(ge_y_w) << B);
                div_reg[k]   <= div_reg[k-1];
                side_reg[k]  <= side_reg[k-1];
            end
        end
    end

    assign out_valid      = vld_reg[QUO_W];
    assign out_data.hit   = side_reg[QUO_W].hit;
    assign out_data.neg_x = side_reg[QUO_W].neg_x;
    assign out_data.neg_y = side_reg[QUO_W].neg_y;
    assign out_data.ovf_x = side_reg[QUO_W].ovf_x;
    assign out_data.ovf_y = side_reg[QUO_W].ovf_y;
    assign out_data.q_x   = q_x_reg[QUO_W];
    assign out_data.q_y   = q_y_reg[QUO_W];

endmodule

// ----- sv/srp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the segment repulsion block, bound to the top level.
// Depends on srp_pkg and segment_particle_repulsion_force.
module srp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [srp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);
    import srp_pkg::*;

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // A stalled result is held unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Without a hit both force components are zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("force reported without a hit");

    // The input only backs off while the receiver is stalling a result.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input not ready without an output stall");

endmodule

bind segment_particle_repulsion_force srp_checker u_srp_checker (.*);

// ----- tb/segment_particle_repulsion_force_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for segment_particle_repulsion_force: directed table, then random
// segment/particle phases under several register settings. Depends on srp_pkg and the RTL.
module segment_particle_repulsion_force_test;
    import srp_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        bit          hit;
        logic [31:0] force_x;
        logic [31:0] force_y;
    } force_t;

    typedef struct {
        int          ax, ay, bx, by, px, py;
        int unsigned mass;
        bit          typed;
        bit          hit;
        logic [31:0] fx, fy;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_RADIUS;
    logic [RADIUS_W-1:0]   cfg_wdata = '0;

    logic [RADIUS_W-1:0] radius_q = RADIUS_RESET;
    logic [MARGIN_W-1:0] margin_q = MARGIN_RESET;
    force_t              expected_forces[$];
    int                  errors = 0;
    int                  results_seen = 0;
    bit                  calm = 1'b0;

    segment_particle_repulsion_force dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic wide_t mag(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // Quotient truncated toward zero, clamped to the signed 32-bit range.
    function automatic logic [31:0] clamped_quotient(wide_t num, wide_t den);
        wide_t q;
        q = mag(num) / mag(den);
        if ((num < 0) != (den < 0)) begin
            if (q > wide_t'(64'h80000000)) return SAT_NEG;
            return 32'(-q);
        end
        if (q > wide_t'(64'h7FFFFFFF)) return SAT_POS;
        return q[31:0];
    endfunction

    function automatic force_t wall_force(srp_item_t it);
        wide_t ax, ay, bx, by, px, py, ms, rx, ry, wx, wy, d2, dot, c, m, half, dot16;
        force_t f;
        ax = it.seg_ax; ay = it.seg_ay; bx = it.seg_bx; by = it.seg_by;
        px = it.pos_x; py = it.pos_y;
        ms = it.mass;
        ms = ms * 65536;
        m = margin_q;
        half = 32768 - m;
        rx = bx - ax; ry = by - ay; wx = px - ax; wy = py - ay;
        d2 = rx * rx + ry * ry;
        dot = wx * rx + wy * ry;
        c = wx * ry - wy * rx;
        dot16 = dot * 65536;
        f = '{1'b0, '0, '0};
        if (d2 >= 3 && half > 0 && c != 0 && m * d2 < dot16 && dot16 < (65536 - m) * d2
                && mag(c) * 65536 < 20000 * half * d2
                && c * c < wide_t'(radius_q) * wide_t'(radius_q) * d2) begin
            f.hit = 1'b1;
            f.force_x = clamped_quotient(ms * ry, c);
            f.force_y = clamped_quotient(-ms * rx, c);
        end
        return f;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [RADIUS_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_RADIUS) radius_q = val;
        else margin_q = val[MARGIN_W-1:0];
    endtask

    task automatic drain();
        wait (expected_forces.size() == 0);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_item(srp_item_t it, bit typed, force_t typed_force);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, it};
        do @(posedge aclk); while (!s_tready);
        expected_forces.push_back(typed ? typed_force : wall_force(it));
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic srp_item_t random_item();
        srp_item_t it;
        int span, off;
        if ($urandom_range(0, 9) < 2) begin
            it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom});
            return it;
        end
        span = 1 << $urandom_range(6, 26);
        off = 1 << $urandom_range(2, 20);
        it.seg_ax = int'($urandom_range(0, 2 * span)) - span;
        it.seg_ay = int'($urandom_range(0, 2 * span)) - span;
        it.seg_bx = int'($urandom_range(0, 2 * span)) - span;
        it.seg_by = int'($urandom_range(0, 2 * span)) - span;
        it.pos_x = (it.seg_ax >>> 1) + (it.seg_bx >>> 1) + int'($urandom_range(0, 2 * off)) - off;
        it.pos_y = (it.seg_ay >>> 1) + (it.seg_by >>> 1) + int'($urandom_range(0, 2 * off)) - off;
        it.mass = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18));
        return it;
    endfunction

    // Receiver: random stalls, one long hold-off so that the pipeline fills and stalls its input.
    initial begin
        int stall_left, hold_left;
        force_t want;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_forces.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result hit=%0b fx=%h fy=%h", $time,
                             m_tuser[0], m_tdata[31:0], m_tdata[63:32]);
                end else begin
                    want = expected_forces.pop_front();
                    if (m_tuser[0] !== want.hit) begin
                        errors++;
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tuser[0]);
                    end
                    if (m_tdata[31:0] !== want.force_x) begin
                        errors++;
                        $display("%0t: force_x expected %h actual %h", $time,
                                 want.force_x, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.force_y) begin
                        errors++;
                        $display("%0t: force_y expected %h actual %h", $time,
                                 want.force_y, m_tdata[63:32]);
                    end
                end
                results_seen++;
                stall_left = calm ? 0 : $urandom_range(0, 6);
                if (results_seen == 100) hold_left = 400;
            end
            if (hold_left > 0) hold_left--;
            else if (stall_left > 0) stall_left--;
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        stim_row_t directed_rows[] = '{
            '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            '{65536, 65536, 65536, 65536, 0, 0, 65536, 1, 0, 0, 0},
            '{0, 0, 1, 1, 5, 0, 65536, 1, 0, 0, 0},
            '{0, 0, 2, 0, 1, 1, 65536, 0, 0, 0, 0},
            '{0, 0, 131072, 0, 65536, 0, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 65536, 32768, 65536, 1, 1, 0, 32'h20000},
            '{0, 0, 131072, 0, 65536, 1, 32'h7FFFFFFF, 1, 1, 0, SAT_POS},
            '{0, 0, 131072, 0, 65536, -1, 32'h7FFFFFFF, 1, 1, 0, SAT_NEG},
            '{0, 0, 131072, 0, 200000, 1000, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 0, 1000, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 131072, 1000, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 65536, 131072, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 65536, 65536, 65536, 1, 0, 0, 0},
            '{0, 0, 131072, 0, 65536, 32768, 0, 1, 1, 0, 0},
            '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
              32'h7FFFFFFF, 0, 0, 0, 0},
            '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF, 32'h7FFFFFFF, 1, 0, 0, 0},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 0, 1, 0, 0, 0},
            '{-1, -1, -1, -1, -1, -1, 32'h7FFFFFFF, 1, 0, 0, 0},
            '{131072, 0, 0, 0, 65536, -32768, 65536, 0, 0, 0, 0},
            '{-65536, -65536, 65536, 65536, 0, 16384, 98304, 0, 0, 0, 0},
            '{32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 1, 32'h7FFFFFFF, 0, 0, 0, 0}
        };
        logic [RADIUS_W-1:0] phase_radius[6] = '{31'd65536, 31'd0, 31'h7FFFFFFF,
                                                 31'd40000, 31'd262144, 31'd1048576};
        logic [MARGIN_W-1:0] phase_margin[6] = '{16'd0, 16'd0, 16'd32768,
                                                 16'd32767, 16'd1000, 16'd0};
        srp_item_t it;
        force_t typed_force;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            it.seg_ax = directed_rows[i].ax;
            it.seg_ay = directed_rows[i].ay;
            it.seg_bx = directed_rows[i].bx;
            it.seg_by = directed_rows[i].by;
            it.pos_x = directed_rows[i].px;
            it.pos_y = directed_rows[i].py;
            it.mass = directed_rows[i].mass[MASS_W-1:0];
            typed_force = '{directed_rows[i].hit, directed_rows[i].fx, directed_rows[i].fy};
            send_item(it, directed_rows[i].typed, typed_force);
        end
        s_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_RADIUS, phase_radius[p]);
            write_reg(REG_EDGE_MARGIN, RADIUS_W'(p == 4 ? 16'($urandom_range(0, 32768))
                                                        : phase_margin[p]));
            for (int n = 0; n < 222; n++) begin
                if (n % 74 == 0) calm = $urandom_range(0, 2) == 0;
                send_item(random_item(), 1'b0, typed_force);
            end
            s_tvalid <= 1'b0;
            calm = 1'b0;
            drain();
        end

        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/srp_pkg.sv
sv/srp_geom.sv
sv/srp_div.sv
sv/segment_particle_repulsion_force.sv
sv/srp_checker.sv
tb/segment_particle_repulsion_force_test.sv
